@@ design/bqlp_pkg.sv @@
// Shared types, constants and the microcode table for the biquad low-pass filter.
package bqlp_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int COEF_W             = 16;
    localparam int DELAY_W            = 24;
    localparam int PROD_W             = COEF_W + DELAY_W;
    localparam int CFG_IDX_W          = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coef_set;

    typedef enum logic [2:0] {
        STEP_IDLE = 3'd0,
        STEP_FB2  = 3'd1,
        STEP_FF1  = 3'd2,
        STEP_NODE = 3'd3,
        STEP_FF0  = 3'd4,
        STEP_SUM  = 3'd5,
        STEP_OUT  = 3'd6
    } t_step;

    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } t_coef_sel;

    typedef enum logic [1:0] {
        D_ONE,
        D_TWO,
        D_W
    } t_dat_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_SUB,
        ACC_ADD,
        ACC_LOAD_P
    } t_acc_op;

    typedef enum logic [1:0] {
        J_NEXT,
        J_WAIT_IN,
        J_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_coef_sel coef_sel;
        t_dat_sel  dat_sel;
        t_acc_op   acc_op;
        logic      take_w;
        logic      emit;
        t_jmp      jmp;
        t_step     next;
    } t_ctrl;

    // The multiplier result is registered, so each word accumulates the product
    // that the previous word started.
    function automatic t_ctrl bq_ucode(input t_step step);
        t_ctrl w;
        w = '{C_A1, D_ONE, ACC_LOAD_X, 1'b0, 1'b0, J_WAIT_IN, STEP_FB2};
        case (step)
            STEP_IDLE: w = '{C_A1, D_ONE, ACC_LOAD_X, 1'b0, 1'b0, J_WAIT_IN,  STEP_FB2};
            STEP_FB2:  w = '{C_A2, D_TWO, ACC_SUB,    1'b0, 1'b0, J_NEXT,     STEP_FF1};
            STEP_FF1:  w = '{C_B1, D_ONE, ACC_SUB,    1'b0, 1'b0, J_NEXT,     STEP_NODE};
            STEP_NODE: w = '{C_B2, D_TWO, ACC_LOAD_P, 1'b1, 1'b0, J_NEXT,     STEP_FF0};
            STEP_FF0:  w = '{C_B0, D_W,   ACC_ADD,    1'b0, 1'b0, J_NEXT,     STEP_SUM};
            STEP_SUM:  w = '{C_B0, D_W,   ACC_ADD,    1'b0, 1'b0, J_NEXT,     STEP_OUT};
            STEP_OUT:  w = '{C_B0, D_W,   ACC_HOLD,   1'b0, 1'b1, J_WAIT_OUT, STEP_IDLE};
            default:   w = '{C_A1, D_ONE, ACC_HOLD,   1'b0, 1'b0, J_NEXT,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ design/bqlp_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module bqlp_seq
    import bqlp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl word;

    assign word = bq_ucode(r_step);

    always_comb begin
        case (word.jmp)
            J_NEXT:     n_step = word.next;
            J_WAIT_IN:  n_step = i_in_valid ? word.next : r_step;
            J_WAIT_OUT: n_step = i_out_free ? word.next : r_step;
            default:    n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready = (word.jmp == J_WAIT_IN);

    // The result step only fires once the output register can take it.
    always_comb begin
        o_ctrl      = word;
        o_ctrl.emit = word.emit & i_out_free;
    end

endmodule

@@ design/bqlp_dpath.sv @@
// Datapath: shared multiplier, accumulator, rounding, overflow checks and delay line.
module bqlp_dpath
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  t_coef_set               i_coefs,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic [SAMPLE_WIDTH-1:0] o_y,
    output logic                    o_flag
);

    localparam int XS_W  = SAMPLE_WIDTH + COEF_FRAC_BITS + 1;
    localparam int ACC_W = ((XS_W > PROD_W) ? XS_W : PROD_W) + 2;

    localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);
    localparam logic signed [ACC_W-1:0] D_MAX = {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN = {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [DELAY_W-1:0]      r_w;
    logic                           r_flag;
    logic signed [DELAY_W-1:0]      r_d1;
    logic signed [DELAY_W-1:0]      r_d2;

    logic signed [COEF_W-1:0]  mul_c;
    logic signed [DELAY_W-1:0] mul_d;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   in_scaled;
    logic signed [ACC_W-1:0]   x_ext;
    logic signed [ACC_W-1:0]   acc_half;
    logic signed [ACC_W-1:0]   rnd;
    logic                      w_ovf;
    logic signed [DELAY_W-1:0] x_clamped;

    always_comb begin
        case (i_ctrl.coef_sel)
            C_B0:    mul_c = i_coefs.b0;
            C_B1:    mul_c = i_coefs.b1;
            C_B2:    mul_c = i_coefs.b2;
            C_A1:    mul_c = i_coefs.a1;
            C_A2:    mul_c = i_coefs.a2;
            default: mul_c = i_coefs.b0;
        endcase
        case (i_ctrl.dat_sel)
            D_ONE:   mul_d = r_d1;
            D_TWO:   mul_d = r_d2;
            D_W:     mul_d = r_w;
            default: mul_d = r_d1;
        endcase
    end

    assign n_prod    = mul_c * mul_d;
    assign prod_ext  = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign in_scaled = {{(ACC_W-SAMPLE_WIDTH){i_sample[SAMPLE_WIDTH-1]}}, i_sample}
                       <<< COEF_FRAC_BITS;
    assign x_ext     = {{(ACC_W-SAMPLE_WIDTH){r_x[SAMPLE_WIDTH-1]}}, r_x};

    // Round half up, then drop the fraction bits; one rounder serves w and y.
    assign acc_half = r_acc + HALF;
    assign rnd      = acc_half >>> COEF_FRAC_BITS;
    assign w_ovf    = (rnd > D_MAX) || (rnd < D_MIN);

    always_comb begin
        if (x_ext > D_MAX) begin
            x_clamped = D_MAX[DELAY_W-1:0];
        end else if (x_ext < D_MIN) begin
            x_clamped = D_MIN[DELAY_W-1:0];
        end else begin
            x_clamped = x_ext[DELAY_W-1:0];
        end
        if (rnd > Y_MAX) begin
            o_y = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (rnd < Y_MIN) begin
            o_y = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            o_y = rnd[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (i_ctrl.acc_op)
            ACC_LOAD_X: begin
                r_acc <= in_scaled;
                r_x   <= i_sample;
            end
            ACC_SUB:    r_acc <= r_acc - prod_ext;
            ACC_ADD:    r_acc <= r_acc + prod_ext;
            ACC_LOAD_P: r_acc <= prod_ext;
            default:    r_acc <= r_acc;
        endcase
        if (i_ctrl.take_w) begin
            r_w    <= w_ovf ? x_clamped : rnd[DELAY_W-1:0];
            r_flag <= w_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.emit) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    assign o_flag = r_flag;

endmodule

@@ design/biquad_lowpass_df2.sv @@
// Top level of the direct-form II biquad low-pass filter.
//
// One signed sample enters per transfer on the slave stream and one filtered,
// saturated sample leaves per transfer on the master stream, with a flag in
// tuser when the feedback node overflowed its 24-bit delay range and was
// replaced by the input sample. Coefficients are signed Q2.14 (fraction bits
// set by COEF_FRAC_BITS) and are written through the plain write port while
// the filter is idle; the user must keep to this, as the block does not
// enforce it: index 0 b0, 1 b1, 2 b2, 3 a1, 4 a2; other indexes are ignored.
// The seven-word microcode program runs all five products through one shared
// 16x24 multiplier between the acceptance of a sample and its result entering
// the output register; it is ready for the next sample from the cycle after
// the result fires; the result step waits while the output register is full.
module biquad_lowpass_df2
    import bqlp_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [COEF_W-1:0]                   i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_in
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // filtered_out
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // overflow_reset
    output logic [0:0]                          m_axis_tuser
);

    localparam int TDATA_W = ((SAMPLE_WIDTH+7)/8)*8;

    t_coef_set                 r_coefs;
    logic                      r_out_valid;
    logic [SAMPLE_WIDTH-1:0]   r_out_y;
    logic                      r_out_flag;
    logic                      out_free;
    t_ctrl                     w_ctrl;
    logic [SAMPLE_WIDTH-1:0]   dp_y;
    logic                      dp_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_B0:  r_coefs.b0 <= i_cfg_data;
                REG_B1:  r_coefs.b1 <= i_cfg_data;
                REG_B2:  r_coefs.b2 <= i_cfg_data;
                REG_A1:  r_coefs.a1 <= i_cfg_data;
                REG_A2:  r_coefs.a2 <= i_cfg_data;
                default: r_coefs    <= r_coefs;
            endcase
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    bqlp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (w_ctrl)
    );

    bqlp_dpath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_coefs  (r_coefs),
        .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .o_y      (dp_y),
        .o_flag   (dp_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit) begin
            r_out_y    <= dp_y;
            r_out_flag <= dp_flag;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = TDATA_W'(r_out_y);
    assign m_axis_tuser[0] = r_out_flag;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("filter took a sample while a previous one was in work");

    a_emit_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |-> (!r_out_valid || m_axis_tready))
        else $error("result fired into an occupied output register");

    a_emit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |=> m_axis_tvalid)
        else $error("fired result did not appear on the master stream");

    a_ready_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.emit |=> s_axis_tready)
        else $error("sequencer did not return to wait for the next sample");

    a_coef_a1_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == REG_A1)) |=> (r_coefs.a1 == $past(i_cfg_data)))
        else $error("coefficient a1 write was lost");
`endif

endmodule
